### sv/iso8601_timestamp_parser_unit_defines.svh
// Assertion macros shared by the timestamp parser RTL.
// Needs a clk and an active-high rst in the scope where a macro is used.
`ifndef ISO8601_TIMESTAMP_PARSER_UNIT_DEFINES_SVH
`define ISO8601_TIMESTAMP_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTH

// The expression must never hold.
`define ISOTS_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ISOTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ISOTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ISOTS_ASSERT_NEVER(label, expr, msg)
`define ISOTS_ASSERT_NEXT(label, ante, cons, msg)
`define ISOTS_ASSERT_SAME(label, ante, cons, msg)

`endif

`endif

### sv/isots_pkg.sv
// Types, constants and helper functions of the timestamp parser.
// Used by the scanner, the multiply-accumulate unit and the top level.
`timescale 1ns / 1ps

package isots_pkg;

  typedef enum logic [3:0] {
    STAT_OK         = 4'd0,
    STAT_EMPTY      = 4'd1,
    STAT_LENGTH     = 4'd2,
    STAT_SEP        = 4'd3,
    STAT_DIGIT      = 4'd4,
    STAT_FRAC_SEP   = 4'd5,
    STAT_FRAC_DIGIT = 4'd6,
    STAT_MONTH      = 4'd7,
    STAT_DAY        = 4'd8,
    STAT_HOUR       = 4'd9,
    STAT_MINUTE     = 4'd10,
    STAT_SECOND     = 4'd11,
    STAT_DATE       = 4'd12
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LEAP, S_YEAR, S_C100, S_C400, S_DAYS, S_MDAY,
    S_MHOUR, S_MMIN, S_MSEC, S_MFRAC, S_FLUSH, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE, OP_ADD, OP_ADD_Q, OP_SUB_Q
  } prod_op_t;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [4:0] POS_DASH1    = 5'd4;
  localparam logic [4:0] POS_DASH2    = 5'd7;
  localparam logic [4:0] POS_T        = 5'd10;
  localparam logic [4:0] POS_COLON1   = 5'd13;
  localparam logic [4:0] POS_COLON2   = 5'd16;
  localparam logic [4:0] POS_DOT      = 5'd19;
  localparam logic [4:0] POS_FRAC_END = 5'd22;
  localparam logic [4:0] POS_SAT      = 5'd25;

  localparam logic [4:0] LEN_NO_FRAC = 5'd20;
  localparam logic [4:0] LEN_FRAC1   = 5'd22;
  localparam logic [4:0] LEN_FRAC2   = 5'd23;
  localparam logic [4:0] LEN_FRAC3   = 5'd24;

  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] DAY_MAX    = 7'd31;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;

  localparam int ERR_SEP   = 0;
  localparam int ERR_DIGIT = 1;
  localparam int ERR_FRAC  = 2;

  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 27;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
  localparam int EPOCH_W = 49;
  localparam int Q_SHIFT = 17;
  localparam int Q_W     = 12;

  localparam logic [MUL_B_W-1:0] RECIP_25      = 27'd5243;
  localparam logic [MUL_B_W-1:0] DAYS_PER_YEAR = 27'd365;
  localparam logic [MUL_B_W-1:0] MS_PER_DAY    = 27'd86400000;
  localparam logic [MUL_B_W-1:0] MS_PER_HOUR   = 27'd3600000;
  localparam logic [MUL_B_W-1:0] MS_PER_MIN    = 27'd60000;
  localparam logic [MUL_B_W-1:0] MS_PER_SEC    = 27'd1000;
  localparam logic [13:0]        YEAR_SHIFT    = 14'd400;
  // Offset that moves the shifted proleptic day count onto 1970-01-01, plus one for day - 1.
  localparam logic [EPOCH_W-1:0] DAYS_BIAS     = 49'd865566;

  typedef struct packed {
    logic [4:0]  pos;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  frac;
    logic [3:0]  err;
    logic        dot;
  } scan_t;

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
    prod_op_t           op;
    logic               load;
    logic [EPOCH_W-1:0] load_val;
  } mac_ctl_t;

  function automatic logic [13:0] add_dig(input logic [13:0] acc, input logic [3:0] d);
    return 14'({acc, 3'b000}) + 14'({acc, 1'b0}) + {10'd0, d};
  endfunction

  function automatic logic [4:0] days_in_month(input logic [6:0] m, input logic leap);
    logic [4:0] r;
    r = 5'd31;
    if (m == 7'd2) begin
      r = leap ? 5'd29 : 5'd28;
    end else if (m inside {7'd4, 7'd6, 7'd9, 7'd11}) begin
      r = 5'd30;
    end
    return r;
  endfunction

  // Day of a March-based year on which each month starts.
  function automatic logic [8:0] month_offset(input logic [6:0] m);
    logic [8:0] r;
    case (m)
      7'd1:    r = 9'd306;
      7'd2:    r = 9'd337;
      7'd3:    r = 9'd0;
      7'd4:    r = 9'd31;
      7'd5:    r = 9'd61;
      7'd6:    r = 9'd92;
      7'd7:    r = 9'd122;
      7'd8:    r = 9'd153;
      7'd9:    r = 9'd184;
      7'd10:   r = 9'd214;
      7'd11:   r = 9'd245;
      7'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### sv/isots_scan.sv
// Character scanner: position counter, decimal field accumulators and error flags.
// Depends on isots_pkg.
`timescale 1ns / 1ps

module isots_scan (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           clr,
  input  logic [7:0]     char_code,
  output isots_pkg::scan_t scan
);
  import isots_pkg::*;

  scan_t      scan_next;
  logic       dig;
  logic [3:0] d;

  assign dig = (char_code >= CH_0) && (char_code <= CH_9);
  assign d   = dig ? 4'(char_code - CH_0) : 4'd0;

  always_comb begin
    scan_next = scan;
    if (scan.pos inside {POS_DASH1, POS_DASH2}) begin
      if (char_code != CH_DASH) scan_next.err[ERR_SEP] = 1'b1;
    end else if (scan.pos == POS_T) begin
      if (char_code != CH_T) scan_next.err[ERR_SEP] = 1'b1;
    end else if (scan.pos inside {POS_COLON1, POS_COLON2}) begin
      if (char_code != CH_COLON) scan_next.err[ERR_SEP] = 1'b1;
    end else if (scan.pos < POS_DOT) begin
      if (!dig) scan_next.err[ERR_DIGIT] = 1'b1;
      if (scan.pos < POS_DASH1) begin
        scan_next.year = add_dig(scan.year, d);
      end else if (scan.pos < POS_DASH2) begin
        scan_next.month = 7'(add_dig({7'd0, scan.month}, d));
      end else if (scan.pos < POS_T) begin
        scan_next.day = 7'(add_dig({7'd0, scan.day}, d));
      end else if (scan.pos < POS_COLON1) begin
        scan_next.hour = 7'(add_dig({7'd0, scan.hour}, d));
      end else if (scan.pos < POS_COLON2) begin
        scan_next.minute = 7'(add_dig({7'd0, scan.minute}, d));
      end else begin
        scan_next.second = 7'(add_dig({7'd0, scan.second}, d));
      end
    end else if (scan.pos == POS_DOT) begin
      scan_next.dot = (char_code == CH_DOT);
    end else if (scan.pos <= POS_FRAC_END) begin
      if (!dig) scan_next.err[ERR_FRAC] = 1'b1;
      scan_next.frac = 10'(add_dig({4'd0, scan.frac}, d));
    end
    scan_next.pos = (scan.pos < POS_SAT) ? scan.pos + 5'd1 : POS_SAT;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      scan <= '0;
    end else if (en) begin
      scan <= scan_next;
    end
  end

endmodule

### sv/isots_mac.sv
// Shared multiply-accumulate unit: registered product, then add, add or subtract
// of the product scaled down by 2^17, or a direct load. Depends on isots_pkg.
`timescale 1ns / 1ps

module isots_mac (
  input  logic                            clk,
  input  logic                            rst,
  input  isots_pkg::mac_ctl_t             ctl,
  output logic [isots_pkg::EPOCH_W-1:0]   acc,
  output logic [isots_pkg::Q_W-1:0]       q
);
  import isots_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] p;
  prod_op_t                 op_q;
  logic [EPOCH_W-1:0]       p_q;

  assign prod = $signed(ctl.a) * $signed({1'b0, ctl.b});
  assign p_q  = EPOCH_W'(p >>> Q_SHIFT);
  assign q    = p[Q_SHIFT+Q_W-1:Q_SHIFT];

  always_ff @(posedge clk) begin
    p <= prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= OP_NONE;
    end else begin
      op_q <= ctl.op;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= ctl.load_val;
    end else begin
      case (op_q)
        OP_ADD:   acc <= acc + p[EPOCH_W-1:0];
        OP_ADD_Q: acc <= acc + p_q;
        OP_SUB_Q: acc <= acc - p_q;
        default:  acc <= acc;
      endcase
    end
  end

endmodule

### sv/iso8601_timestamp_parser_unit.sv
// Top level of the UTC timestamp parser: stream ports, sequencer and result register.
// Depends on isots_pkg, isots_scan, isots_mac and the assertion macro header.
`timescale 1ns / 1ps
`include "iso8601_timestamp_parser_unit_defines.svh"

// The parser takes a YYYY-MM-DDTHH:MM:SS[.f|.ff|.fff]Z text one character per
// transfer and gives one result transfer for the character marked with tlast or
// for an item flagged empty in tuser. Every other character is taken without leaving idle.
// A well-formed text ends in a sequence that reuses one multiplier and
// accumulator for the leap-year test, the day count and the conversion to
// milliseconds, so its last character holds the input through the states from
// S_LEAP to S_EMIT. A format or range error or an empty item holds it in S_EMIT
// alone, a calendar date error in S_LEAP, S_YEAR and S_EMIT. A result waits in an
// output register, and S_EMIT also holds while that register is full and a new result is due.
module iso8601_timestamp_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,
  input  logic        s_tuser,   // [0] empty_string
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // [3:0] status, [52:4] epoch_ms, [55:53] zero
);
  import isots_pkg::*;

  state_t             state;
  state_t             state_next;
  status_t            status_r;
  status_t            status_next;
  status_t            pre_status;
  logic [6:0]         scale_r;
  logic [6:0]         scale_next;
  logic [6:0]         scale_pre;
  scan_t              scan;
  logic               in_fire;
  logic               scan_en;
  logic               scan_clr;
  logic               out_load;
  mac_ctl_t           ctl;
  logic [EPOCH_W-1:0] acc;
  logic [Q_W-1:0]     q;
  logic [4:0]         n;
  logic               has_frac;
  logic [13:0]        yy;
  logic [16:0]        q25;
  logic               div100;
  logic               leap;
  logic [4:0]         dim;

  assign in_fire  = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign scan_en  = in_fire && !s_tlast && !s_tuser;
  assign scan_clr = out_load;

  isots_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .en        (scan_en),
    .clr       (scan_clr),
    .char_code (s_tdata),
    .scan      (scan)
  );

  isots_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .acc (acc),
    .q   (q)
  );

  assign n        = scan.pos + 5'd1;
  assign has_frac = (n != LEN_NO_FRAC);
  assign yy       = scan.year + YEAR_SHIFT - {13'd0, (scan.month <= 7'd2)};
  assign q25      = {1'b0, q, 4'b0000} + {2'b00, q, 3'b000} + {5'd0, q};
  assign div100   = (q25 == {5'd0, scan.year[13:2]});
  assign leap     = (scan.year[1:0] == 2'b00) && (!div100 || (scan.year[3:2] == 2'b00));
  assign dim      = days_in_month(scan.month, leap);

  always_comb begin
    pre_status = STAT_OK;
    if (!(n == LEN_NO_FRAC || n == LEN_FRAC1 || n == LEN_FRAC2 || n == LEN_FRAC3)) begin
      pre_status = STAT_LENGTH;
    end else if (scan.err[ERR_SEP] || s_tdata != CH_Z) begin
      pre_status = STAT_SEP;
    end else if (scan.err[ERR_DIGIT]) begin
      pre_status = STAT_DIGIT;
    end else if (has_frac && !scan.dot) begin
      pre_status = STAT_FRAC_SEP;
    end else if (has_frac && scan.err[ERR_FRAC]) begin
      pre_status = STAT_FRAC_DIGIT;
    end else if (scan.month == 7'd0 || scan.month > MONTH_MAX) begin
      pre_status = STAT_MONTH;
    end else if (scan.day == 7'd0 || scan.day > DAY_MAX) begin
      pre_status = STAT_DAY;
    end else if (scan.hour > HOUR_MAX) begin
      pre_status = STAT_HOUR;
    end else if (scan.minute > MINSEC_MAX) begin
      pre_status = STAT_MINUTE;
    end else if (scan.second > MINSEC_MAX) begin
      pre_status = STAT_SECOND;
    end
  end

  always_comb begin
    case (n)
      LEN_FRAC1: scale_pre = 7'd100;
      LEN_FRAC2: scale_pre = 7'd10;
      LEN_FRAC3: scale_pre = 7'd1;
      default:   scale_pre = 7'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status_r <= STAT_OK;
      scale_r  <= 7'd0;
    end else begin
      state    <= state_next;
      status_r <= status_next;
      scale_r  <= scale_next;
    end
  end

  always_comb begin
    state_next  = state;
    status_next = status_r;
    scale_next  = scale_r;
    ctl         = '0;
    ctl.op      = OP_NONE;
    out_load    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_fire && s_tuser) begin
          status_next = STAT_EMPTY;
          state_next  = S_EMIT;
        end else if (in_fire && s_tlast) begin
          status_next = pre_status;
          scale_next  = scale_pre;
          state_next  = (pre_status == STAT_OK) ? S_LEAP : S_EMIT;
        end
      end
      S_LEAP: begin
        ctl.a      = {12'd0, scan.year[13:2]};
        ctl.b      = RECIP_25;
        state_next = S_YEAR;
      end
      S_YEAR: begin
        if ({2'b00, dim} < scan.day) begin
          status_next = STAT_DATE;
          state_next  = S_EMIT;
        end else begin
          ctl.a        = {10'd0, yy};
          ctl.b        = DAYS_PER_YEAR;
          ctl.op       = OP_ADD;
          ctl.load     = 1'b1;
          ctl.load_val = EPOCH_W'(yy[13:2]) + EPOCH_W'(month_offset(scan.month))
                       + EPOCH_W'(scan.day) - DAYS_BIAS;
          state_next   = S_C100;
        end
      end
      S_C100: begin
        ctl.a      = {12'd0, yy[13:2]};
        ctl.b      = RECIP_25;
        ctl.op     = OP_SUB_Q;
        state_next = S_C400;
      end
      S_C400: begin
        ctl.a      = {14'd0, yy[13:4]};
        ctl.b      = RECIP_25;
        ctl.op     = OP_ADD_Q;
        state_next = S_DAYS;
      end
      S_DAYS: begin
        state_next = S_MDAY;
      end
      S_MDAY: begin
        ctl.a        = acc[MUL_A_W-1:0];
        ctl.b        = MS_PER_DAY;
        ctl.op       = OP_ADD;
        ctl.load     = 1'b1;
        ctl.load_val = '0;
        state_next   = S_MHOUR;
      end
      S_MHOUR: begin
        ctl.a      = {17'd0, scan.hour};
        ctl.b      = MS_PER_HOUR;
        ctl.op     = OP_ADD;
        state_next = S_MMIN;
      end
      S_MMIN: begin
        ctl.a      = {17'd0, scan.minute};
        ctl.b      = MS_PER_MIN;
        ctl.op     = OP_ADD;
        state_next = S_MSEC;
      end
      S_MSEC: begin
        ctl.a      = {17'd0, scan.second};
        ctl.b      = MS_PER_SEC;
        ctl.op     = OP_ADD;
        state_next = S_MFRAC;
      end
      S_MFRAC: begin
        ctl.a      = {14'd0, scan.frac};
        ctl.b      = {20'd0, scale_r};
        ctl.op     = OP_ADD;
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, ((status_r == STAT_OK) ? acc : {EPOCH_W{1'b0}}), status_r};
    end
  end

  `ISOTS_ASSERT_NEXT(a_busy_after_end, in_fire && (s_tlast || s_tuser), !s_tready, "input taken while a result is pending")
  `ISOTS_ASSERT_NEVER(a_err_epoch_zero, m_tvalid && (m_tdata[3:0] != STAT_OK) && (m_tdata[52:4] != '0), "nonzero epoch with error status")
  `ISOTS_ASSERT_NEVER(a_status_code, m_tvalid && (m_tdata[3:0] > STAT_DATE), "status code out of range")
  `ISOTS_ASSERT_NEXT(a_emit_done, (state == S_EMIT) && (!m_tvalid || m_tready), m_tvalid && s_tready, "result not delivered on emit")

endmodule

### tb/isots_epoch_monitor.sv
// Result monitor for the UTC timestamp parser: it tracks every accepted character,
// predicts the status and epoch milliseconds of each finished text and checks the
// result channel in order. Depends on isots_pkg for the status codes and characters.
`timescale 1ns / 1ps

module isots_epoch_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,
  input  logic        s_tuser,   // [0] empty_string
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // [3:0] status, [52:4] epoch_ms, [55:53] zero
  output int          mismatches,
  output int          outstanding
);
  import isots_pkg::*;

  typedef struct {
    status_t     code;
    logic [48:0] ms;
  } stamp_t;

  stamp_t due_stamps[$];

  logic [4:0]  pos;
  logic [13:0] yr;
  logic [6:0]  mon, dd, hh, mm, ss;
  logic [9:0]  frac;
  logic [3:0]  flags;
  logic        dot19;

  function automatic void clear_scan();
    pos = '0;
    yr = '0;
    mon = '0;
    dd = '0;
    hh = '0;
    mm = '0;
    ss = '0;
    frac = '0;
    flags = '0;
    dot19 = 1'b0;
  endfunction

  function automatic int month_length(input int y, input int m);
    bit leap;
    leap = (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    if (m == 2) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // Day count from 1970-01-01, using a March-based year shifted by 400 years.
  function automatic longint day_number(input int y, input int m, input int d);
    longint yy, era, yoe, mp, doy, doe;
    yy = y + 400 - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468 - 146097;
  endfunction

  function automatic status_t judge_text(input logic [7:0] ch, output logic [48:0] ms);
    int     n, scale;
    longint total;
    ms = '0;
    n = int'(pos) + 1;
    scale = 0;
    if (n != LEN_NO_FRAC && n != LEN_FRAC1 && n != LEN_FRAC2 && n != LEN_FRAC3)
      return STAT_LENGTH;
    if (flags[ERR_SEP] || ch != CH_Z) return STAT_SEP;
    if (flags[ERR_DIGIT]) return STAT_DIGIT;
    if (n > LEN_NO_FRAC) begin
      if (!dot19) return STAT_FRAC_SEP;
      if (flags[ERR_FRAC]) return STAT_FRAC_DIGIT;
      scale = (n == LEN_FRAC1) ? 100 : (n == LEN_FRAC2) ? 10 : 1;
    end
    if (mon < 1 || mon > MONTH_MAX) return STAT_MONTH;
    if (dd < 1 || dd > DAY_MAX) return STAT_DAY;
    if (hh > HOUR_MAX) return STAT_HOUR;
    if (mm > MINSEC_MAX) return STAT_MINUTE;
    if (ss > MINSEC_MAX) return STAT_SECOND;
    if (int'(dd) > month_length(int'(yr), int'(mon))) return STAT_DATE;
    total = day_number(int'(yr), int'(mon), int'(dd)) * 64'sd86400000
          + longint'(int'(hh)) * 3600000 + longint'(int'(mm)) * 60000
          + longint'(int'(ss)) * 1000 + longint'(int'(frac) * scale);
    ms = 49'(total);
    return STAT_OK;
  endfunction

  // Returns 1 when the character closes a text or is flagged empty, so a result is due.
  function automatic bit parse_char(input logic [7:0] ch, input logic fin,
                                    input logic blank, output stamp_t res);
    logic        isdig;
    logic [3:0]  d;
    logic [48:0] ms_v;
    isdig = (ch >= CH_0) && (ch <= CH_9);
    d = isdig ? 4'(ch - CH_0) : 4'd0;
    res.code = STAT_EMPTY;
    res.ms = '0;
    if (blank) begin
      clear_scan();
      return 1'b1;
    end
    if (!fin) begin
      if (pos == POS_DASH1 || pos == POS_DASH2) begin
        if (ch != CH_DASH) flags[ERR_SEP] = 1'b1;
      end else if (pos == POS_T) begin
        if (ch != CH_T) flags[ERR_SEP] = 1'b1;
      end else if (pos == POS_COLON1 || pos == POS_COLON2) begin
        if (ch != CH_COLON) flags[ERR_SEP] = 1'b1;
      end else if (pos < POS_DOT) begin
        if (!isdig) flags[ERR_DIGIT] = 1'b1;
        if (pos < POS_DASH1) yr = 14'(yr * 10 + d);
        else if (pos < POS_DASH2) mon = 7'(mon * 10 + d);
        else if (pos < POS_T) dd = 7'(dd * 10 + d);
        else if (pos < POS_COLON1) hh = 7'(hh * 10 + d);
        else if (pos < POS_COLON2) mm = 7'(mm * 10 + d);
        else ss = 7'(ss * 10 + d);
      end else if (pos == POS_DOT) begin
        dot19 = (ch == CH_DOT);
      end else if (pos <= POS_FRAC_END) begin
        if (!isdig) flags[ERR_FRAC] = 1'b1;
        frac = 10'(frac * 10 + d);
      end
      if (pos < POS_SAT) pos = pos + 5'd1;
      return 1'b0;
    end
    res.code = judge_text(ch, ms_v);
    res.ms = ms_v;
    clear_scan();
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch in %s, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    stamp_t want;
    if (rst) begin
      clear_scan();
      due_stamps.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_stamps.size() == 0) begin
          flag_mismatch("unexpected result status", m_tdata[3:0], -1);
        end else begin
          want = due_stamps.pop_front();
          if (m_tdata[3:0] !== want.code)
            flag_mismatch("status", m_tdata[3:0], want.code);
          if (m_tdata[52:4] !== want.ms)
            flag_mismatch("epoch_ms", $signed(m_tdata[52:4]), $signed(want.ms));
          if (m_tdata[55:53] !== 3'd0)
            flag_mismatch("padding", m_tdata[55:53], 0);
        end
      end
      if (s_tvalid && s_tready) begin
        if (parse_char(s_tdata, s_tlast, s_tuser, want)) due_stamps.push_back(want);
      end
    end
    outstanding = due_stamps.size();
  end

endmodule

### tb/iso8601_timestamp_parser_unit_tb.sv
// Testbench top for the UTC timestamp parser: clock, reset, character stimulus
// and the result-side stall pattern. Depends on isots_pkg, the parser RTL and
// isots_epoch_monitor, which does all prediction and checking.
`timescale 1ns / 1ps

module iso8601_timestamp_parser_unit_tb;
  import isots_pkg::*;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BUSY} rx_style_t;

  localparam int    RANDOM_CHARS = 725;
  localparam int    HOLD_CYCLES  = 300;
  localparam int    DRAIN_CYCLES = 40;
  localparam string SYMBOLS      = "0123456789-T:.Z";
  localparam int    LANDMARK_YEARS [10] = '{0, 4, 100, 400, 1600, 1900, 2000, 2100, 9996, 9999};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  int         mismatches;
  int         outstanding;
  int         burst_left = 0;
  int         sent_chars = 0;
  bit         hold_off_req = 1'b0;
  logic [7:0] text_buf[$];

  always #2 clk = ~clk;

  iso8601_timestamp_parser_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  isots_epoch_monitor stamp_mon (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  task automatic send_char(input logic [7:0] ch, input logic fin, input logic blank);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tlast <= fin;
    s_tuser <= blank;
    do @(posedge clk); while (!s_tready);
    sent_chars++;
  endtask

  task automatic send_text(input bit closed);
    for (int i = 0; i < text_buf.size(); i++)
      send_char(text_buf[i], closed && (i == text_buf.size() - 1), 1'b0);
  endtask

  task automatic send_blank();
    send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  function automatic void load_str(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  task automatic send_str(input string s);
    load_str(s);
    send_text(1'b1);
  endtask

  function automatic logic [7:0] noise_char();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return SYMBOLS[$urandom_range(0, SYMBOLS.len() - 1)];
  endfunction

  // Stop offering characters until every due result has been taken.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  task automatic send_random_text();
    int    kind, y, mo, dy, h, mi, sc, p;
    string s;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      text_buf.delete();
      repeat ($urandom_range(1, 30)) text_buf.push_back(noise_char());
      send_text(1'b1);
      return;
    end
    if (kind < 16) begin
      send_blank();
      return;
    end
    y = ($urandom_range(0, 3) == 0) ? LANDMARK_YEARS[$urandom_range(0, 9)]
                                    : $urandom_range(0, 9999);
    mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    if ($urandom_range(0, 9) == 0) dy = $urandom_range(0, 99);
    else if ($urandom_range(0, 2) == 0) dy = $urandom_range(28, 31);
    else dy = $urandom_range(1, 31);
    h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    mi = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    sc = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d", y, mo, dy, h, mi, sc);
    case ($urandom_range(0, 3))
      1: s = {s, $sformatf(".%01d", $urandom_range(0, 9))};
      2: s = {s, $sformatf(".%02d", $urandom_range(0, 99))};
      3: s = {s, $sformatf(".%03d", $urandom_range(0, 999))};
      default: ;
    endcase
    load_str({s, "Z"});
    if (kind < 32) begin
      p = $urandom_range(0, text_buf.size() - 1);
      text_buf[p] = noise_char();
    end else if (kind < 38) begin
      p = $urandom_range(0, text_buf.size() - 1);
      if ($urandom_range(0, 1)) text_buf.insert(p, noise_char());
      else text_buf.delete(p);
    end else if (kind < 44) begin
      repeat ($urandom_range(1, 8))
        text_buf.insert(text_buf.size() - 1, 8'(CH_0 + $urandom_range(0, 9)));
    end else if (kind < 50) begin
      repeat ($urandom_range(1, text_buf.size() - 1)) void'(text_buf.pop_back());
      send_text(1'b0);
      send_blank();
      return;
    end
    send_text(1'b1);
  endtask

  initial begin : sink
    rx_style_t style;
    int        left;
    left = 0;
    style = RX_OPEN;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if (left == 0) begin
        style = rx_style_t'($urandom_range(0, 3));
        left = $urandom_range(16, 128);
      end
      left--;
      case (style)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
        default:   m_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin : stimulus
    int rand_start;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_str("1970-01-01T00:00:00Z");
    send_str("0000-01-01T00:00:00Z");
    send_str("9999-12-31T23:59:59.999Z");
    send_str("1969-12-31T23:59:59.999Z");
    send_str("2000-02-29T12:34:56.7Z");
    send_str("2024-02-29T01:02:03.45Z");
    send_str("1900-02-29T00:00:00Z");
    send_str("2023-04-31T00:00:00Z");
    send_str("2023-00-10T00:00:00Z");
    send_str("2023-13-10T00:00:00Z");
    send_str("2023-01-00T00:00:00Z");
    send_str("2023-01-32T00:00:00Z");
    send_str("2023-01-01T24:00:00Z");
    send_str("2023-01-01T00:60:00Z");
    send_str("2023-01-01T00:00:60Z");
    send_str("2023-01-01T00:00:00.Z");
    send_str("2023/01-01T00:00:00Z");
    send_str("2023-01-01T00:00:00X");
    send_str("2O23-01-01T00:00:00Z");
    send_str("2023-01-01T00:00:00,5Z");
    send_str("2023-01-01T00:00:00.5aZ");
    send_str("2023-01-01T00:00:00.123456Z");
    send_str("Z");
    send_blank();
    load_str("2023-01");
    send_text(1'b0);
    send_blank();
    settle();

    // The result side holds off at the start of the random texts, so the input backs up.
    hold_off_req = 1'b1;
    rand_start = sent_chars;
    while (sent_chars < rand_start + RANDOM_CHARS) begin
      send_random_text();
      if ($urandom_range(0, 19) == 0) settle();
    end

    s_tvalid <= 1'b0;
    @(negedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule
